// ===== hw/rtl/mandelbrot_escape_time_top_macros.svh =====
// assertion macros for the mandelbrot escape-time block checker
`ifndef MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MET_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/met_pkg.sv =====
// shared types, constants and helpers of the mandelbrot escape-time block
package met_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int FRAC_BITS   = 26;
    localparam int COUNT_BITS  = 16;

    localparam int COL_W     = 12;
    localparam int ROW_W     = 12;
    localparam int COORD_W   = 32;
    localparam int ITER_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // squares of a coordinate after the fraction shift, always non-negative
    localparam int SQ_W = 2 * COORD_W - FRAC_BITS - 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // front register, queue, iterator and result register
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;
    localparam int PEND_W       = $clog2(MAX_INFLIGHT + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER = 3'd0,
        CFG_X_ORIGIN = 3'd1,
        CFG_X_STEP   = 3'd2,
        CFG_Y_ORIGIN = 3'd3,
        CFG_Y_STEP   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_TEST
    } t_iter_state;

    typedef struct packed {
        logic [ITER_W-1:0]  max_iter;
        logic [COORD_W-1:0] x_origin;
        logic [COORD_W-1:0] x_step;
        logic [COORD_W-1:0] y_origin;
        logic [COORD_W-1:0] y_step;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] re;
        logic [COORD_W-1:0] im;
    } t_coord;

    function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] col);
        logic [COL_W-1:0] res;
        res = col;
        if (32'(col) >= 32'(MAX_COLUMNS)) begin
            res = COL_W'(MAX_COLUMNS - 1);
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] res;
        res = row;
        if (32'(row) >= 32'(MAX_ROWS)) begin
            res = ROW_W'(MAX_ROWS - 1);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/met_if.sv =====
// request channel interfaces: pixel requests in, escape counts out
interface met_pix_if import met_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;

    modport source (output valid, column, row, input ready);
    modport sink   (input valid, column, row, output ready);
endinterface

interface met_res_if import met_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] iterations;

    modport source (output valid, iterations, input ready);
    modport sink   (input valid, iterations, output ready);
endinterface

// ===== hw/rtl/met_front.sv =====
// front end: takes pixel requests and maps them to the complex point c
module met_front import met_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    met_pix_if.sink       i_pix,
    output logic          o_coord_valid,
    output t_coord        o_coord,
    input  logic          i_coord_ready
);

    logic             r_valid;
    t_coord           r_coord;
    t_coord           n_coord;
    logic             accept;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;

    assign i_pix.ready = !r_valid || i_coord_ready;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        col        = clamp_col(i_pix.column);
        row        = clamp_row(i_pix.row);
        n_coord.re = COORD_W'(COORD_W'(col) * i_cfg.x_step) + i_cfg.x_origin;
        n_coord.im = COORD_W'(COORD_W'(row) * i_cfg.y_step) + i_cfg.y_origin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_coord_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord_valid = r_valid;
    assign o_coord       = r_coord;

endmodule

// ===== hw/rtl/met_queue.sv =====
// small fifo of mapped points between the front end and the iterator
module met_queue import met_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_coord i_push_data,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_coord o_pop_data
);

    t_coord            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/met_iter.sv =====
// back end: iterates z = z*z + c in a multiply state and a test state, and holds the result
module met_iter import met_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ITER_W-1:0] i_max_iter,
    input  logic              i_coord_valid,
    output logic              o_coord_ready,
    input  t_coord            i_coord,
    met_res_if.source         o_res
);

    t_iter_state r_state;
    t_iter_state n_state;

    logic signed [COORD_W-1:0] r_zr;
    logic signed [COORD_W-1:0] r_zi;
    logic [COORD_W-1:0]        r_cr;
    logic [COORD_W-1:0]        r_ci;
    logic [SQ_W-1:0]           r_sqr;
    logic [SQ_W-1:0]           r_sqi;
    logic [COORD_W-1:0]        r_cross;
    logic [COUNT_BITS-1:0]     r_cnt;
    logic                      r_res_valid;
    logic [ITER_W-1:0]         r_res_iter;

    logic signed [2*COORD_W-1:0] p_rr;
    logic signed [2*COORD_W-1:0] p_ii;
    logic signed [2*COORD_W-1:0] p_ri;
    logic [SQ_W:0]               mag;
    logic [COUNT_BITS-1:0]       limit;
    logic                        done;
    logic                        slot_free;
    logic                        load;
    logic                        step;
    logic                        res_wr;

    // squares and cross product of the current z
    always_comb begin
        p_rr = $signed(r_zr) * $signed(r_zr);
        p_ii = $signed(r_zi) * $signed(r_zi);
        p_ri = $signed(r_zr) * $signed(r_zi);
    end

    always_comb begin
        mag   = {1'b0, r_sqr} + {1'b0, r_sqi};
        limit = (32'(i_max_iter) < 32'(CNT_MAX)) ? COUNT_BITS'(i_max_iter) : CNT_MAX;
        done  = (mag >= ((SQ_W + 1)'(4) << FRAC_BITS)) || (r_cnt >= limit);
        slot_free = !r_res_valid || o_res.ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_coord_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_TEST;
            end
            ST_TEST: begin
                if (!done) begin
                    n_state = ST_MUL;
                end else if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        load   = 1'b0;
        step   = 1'b0;
        res_wr = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                load = i_coord_valid;
            end
            ST_MUL: begin
            end
            ST_TEST: begin
                step   = !done;
                res_wr = done && slot_free;
            end
            default: begin
            end
        endcase
    end

    assign o_coord_ready = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_wr) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            // first pass from z = 0 gives z = c without counting
            r_cr  <= i_coord.re;
            r_ci  <= i_coord.im;
            r_zr  <= $signed(i_coord.re);
            r_zi  <= $signed(i_coord.im);
            r_cnt <= '0;
        end else if (step) begin
            r_zr  <= $signed(r_sqr[COORD_W-1:0] - r_sqi[COORD_W-1:0] + r_cr);
            r_zi  <= $signed(r_cross + r_ci);
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == ST_MUL) begin
            r_sqr   <= SQ_W'(p_rr >>> FRAC_BITS);
            r_sqi   <= SQ_W'(p_ii >>> FRAC_BITS);
            r_cross <= COORD_W'(p_ri >>> (FRAC_BITS - 1));
        end
        if (res_wr) begin
            r_res_iter <= ITER_W'(r_cnt);
        end
    end

    assign o_res.valid      = r_res_valid;
    assign o_res.iterations = r_res_iter;

endmodule

// ===== hw/rtl/mandelbrot_escape_time_top.sv =====
// top level of the mandelbrot escape-time block
// Each pixel request (column, row) is mapped to c = origin + index*step in
// signed Q6.26 and iterated as z = z*z + c from z = 0 until |z|^2 reaches 4.0
// or the count reaches max_iter; the count goes out as one result request.
// The front end registers the mapped point, a two-entry queue sits behind
// it, and the iterator runs each pass as a multiply state for the three
// 32x32 products and then a test state for the add, escape test and count.
// Up to five requests can be in flight; the next pixel is mapped and queued
// while one iterates and a finished count waits at the output. The user must
// write configuration through i_cfg_we/i_cfg_idx/i_cfg_data only while the
// block is idle; the block itself does not enforce it. Indexes past the last
// register are ignored.
module mandelbrot_escape_time_top import met_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    met_pix_if.sink               i_pix,
    met_res_if.source             o_res
);

    // configuration registers
    t_cfg   r_cfg;

    // mapped points from the front end into the queue
    logic   front_valid;
    logic   front_ready;
    t_coord front_coord;

    // queue head into the iterator
    logic   q_valid;
    logic   q_ready;
    t_coord q_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iter <= ITER_W'(256);
            r_cfg.x_origin <= '0;
            r_cfg.x_step   <= '0;
            r_cfg.y_origin <= '0;
            r_cfg.y_step   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_ITER: r_cfg.max_iter <= ITER_W'(i_cfg_data);
                CFG_X_ORIGIN: r_cfg.x_origin <= COORD_W'(i_cfg_data);
                CFG_X_STEP:   r_cfg.x_step   <= COORD_W'(i_cfg_data);
                CFG_Y_ORIGIN: r_cfg.y_origin <= COORD_W'(i_cfg_data);
                CFG_Y_STEP:   r_cfg.y_step   <= COORD_W'(i_cfg_data);
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // pixel index to complex point
    met_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_pix         (i_pix),
        .o_coord_valid (front_valid),
        .o_coord       (front_coord),
        .i_coord_ready (front_ready)
    );

    // decouples mapping from iteration
    met_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_coord),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_coord)
    );

    // escape-time loop and result register
    met_iter u_iter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_iter    (r_cfg.max_iter),
        .i_coord_valid (q_valid),
        .o_coord_ready (q_ready),
        .i_coord       (q_coord),
        .o_res         (o_res)
    );

endmodule

// ===== hw/rtl/met_checker.sv =====
// port-level checker of the mandelbrot escape-time block and its bind
`include "mandelbrot_escape_time_top_macros.svh"

module met_checker import met_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_pix_valid,
    input logic                  i_pix_ready,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic [ITER_W-1:0]     i_res_iterations
);

    logic [ITER_W-1:0] r_max_iter;
    logic [PEND_W-1:0] r_pend;
    logic              acc_in;
    logic              acc_out;

    assign acc_in  = i_pix_valid && i_pix_ready;
    assign acc_out = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= ITER_W'(256);
            r_pend     <= '0;
        end else begin
            if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_MAX_ITER)) begin
                r_max_iter <= ITER_W'(i_cfg_data);
            end
            if (acc_in && !acc_out) begin
                r_pend <= r_pend + 1'b1;
            end else if (acc_out && !acc_in) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    `MET_ASSERT_SAME(a_count_capped, i_res_valid, i_res_iterations <= r_max_iter,
        "count above limit")
    `MET_ASSERT_SAME(a_no_orphan_result, i_res_valid, r_pend != '0,
        "result without pending request")
    `MET_ASSERT_SAME(a_full_blocks_input, r_pend == PEND_W'(MAX_INFLIGHT), !i_pix_ready,
        "input taken while full")
    `MET_ASSERT_NEXT(a_result_held, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_iterations), "stalled result changed")

endmodule

bind mandelbrot_escape_time_top met_checker u_met_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cfg_we         (i_cfg_we),
    .i_cfg_idx        (i_cfg_idx),
    .i_cfg_data       (i_cfg_data),
    .i_pix_valid      (i_pix.valid),
    .i_pix_ready      (i_pix.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_iterations (o_res.iterations)
);
